@@ rtl/core/scfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants for the sum-checked frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int MAX_PACKAGE_BYTES_DEF = 1024;

    localparam logic [7:0]  HEAD_BYTE = 8'h11;
    localparam logic [7:0]  TAIL_BYTE = 8'h16;
    localparam logic [15:0] MIN_LENGTH = 16'd2;

    typedef logic [2:0] t_verdict;

    localparam t_verdict V_OK         = 3'd0;
    localparam t_verdict V_BAD_TAIL   = 3'd1;
    localparam t_verdict V_BAD_HEAD   = 3'd2;
    localparam t_verdict V_BAD_LENGTH = 3'd3;
    localparam t_verdict V_BAD_SUM    = 3'd4;
    localparam t_verdict V_TOO_LONG   = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_package;
    } t_item;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        t_verdict   verdict;
    } t_result;

endpackage

@@ rtl/core/scfp_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_in_stage
// Input register: captures one byte transaction and holds it until the
// parser advances it.
// ----------------------------------------------------------------------------
module scfp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  scfp_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_item_valid,
    output scfp_pkg::t_item o_item
);
    import scfp_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  take;

    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;
    assign n_valid = take || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

@@ rtl/core/scfp_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_parse
// Frame state and per-byte decode: length, running sum, checksum capture and
// the end-of-package verdict.
// ----------------------------------------------------------------------------
module scfp_parse #(
    parameter int MAX_PACKAGE_BYTES = scfp_pkg::MAX_PACKAGE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scfp_pkg::t_item   i_item,
    input  logic              i_advance,
    output logic              o_has_result,
    output scfp_pkg::t_result o_result
);
    import scfp_pkg::*;

    localparam logic [15:0] LIMIT = 16'(MAX_PACKAGE_BYTES);

    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_declared_length, n_declared_length;
    logic [23:0] r_running_sum, n_running_sum;
    logic [15:0] r_received_checksum, n_received_checksum;
    logic        r_head_seen_ok, n_head_seen_ok;
    logic        r_overlong_flag, n_overlong_flag;

    logic [7:0]  b;
    logic        payload;
    logic        len_ok;
    logic [16:0] idx_ext;
    logic [16:0] len_ext;
    t_verdict    verdict;

    assign b       = i_item.rx_byte;
    assign idx_ext = {1'b0, r_byte_index};
    assign len_ext = {1'b0, r_declared_length};

    always_comb begin
        n_byte_index        = r_byte_index;
        n_declared_length   = r_declared_length;
        n_running_sum       = r_running_sum;
        n_received_checksum = r_received_checksum;
        n_head_seen_ok      = r_head_seen_ok;
        n_overlong_flag     = r_overlong_flag || (r_byte_index >= LIMIT);
        payload             = 1'b0;

        if (r_byte_index == 16'd0) begin
            n_head_seen_ok = (b == HEAD_BYTE);
        end else if (r_byte_index == 16'd1) begin
            n_declared_length = {b, 8'h00};
            n_running_sum     = r_running_sum + 24'(b);
        end else if (r_byte_index == 16'd2) begin
            n_declared_length = {r_declared_length[15:8], b};
            n_running_sum     = r_running_sum + 24'(b);
        end else begin
            if (r_byte_index <= r_declared_length) begin
                n_running_sum = r_running_sum + 24'(b);
                payload       = 1'b1;
            end
            if ((r_declared_length >= MIN_LENGTH) && (idx_ext == len_ext + 17'd1)) begin
                n_received_checksum[15:8] = b;
            end
            if ((r_declared_length >= MIN_LENGTH) && (idx_ext == len_ext + 17'd2)) begin
                n_received_checksum[7:0] = b;
            end
        end

        len_ok = (n_declared_length >= MIN_LENGTH)
              && (({1'b0, n_declared_length} + 17'd2) <= idx_ext);

        if (n_overlong_flag) begin
            verdict = V_TOO_LONG;
        end else if (b != TAIL_BYTE) begin
            verdict = V_BAD_TAIL;
        end else if (!n_head_seen_ok) begin
            verdict = V_BAD_HEAD;
        end else if (!len_ok) begin
            verdict = V_BAD_LENGTH;
        end else if (n_running_sum[15:0] != n_received_checksum) begin
            verdict = V_BAD_SUM;
        end else begin
            verdict = V_OK;
        end

        if (i_item.end_of_package) begin
            o_has_result          = 1'b1;
            o_result.item_kind    = KIND_VERDICT;
            o_result.payload_byte = 8'h00;
            o_result.verdict      = verdict;
            n_byte_index          = 16'd0;
            n_declared_length     = 16'd0;
            n_running_sum         = 24'd0;
            n_received_checksum   = 16'd0;
            n_head_seen_ok        = 1'b0;
            n_overlong_flag       = 1'b0;
        end else begin
            o_has_result          = payload && n_head_seen_ok && !n_overlong_flag;
            o_result.item_kind    = KIND_PAYLOAD;
            o_result.payload_byte = b;
            o_result.verdict      = V_OK;
            if (r_byte_index != 16'hFFFF) begin
                n_byte_index = r_byte_index + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index        <= 16'd0;
            r_declared_length   <= 16'd0;
            r_running_sum       <= 24'd0;
            r_received_checksum <= 16'd0;
            r_head_seen_ok      <= 1'b0;
            r_overlong_flag     <= 1'b0;
        end else if (i_advance) begin
            r_byte_index        <= n_byte_index;
            r_declared_length   <= n_declared_length;
            r_running_sum       <= n_running_sum;
            r_received_checksum <= n_received_checksum;
            r_head_seen_ok      <= n_head_seen_ok;
            r_overlong_flag     <= n_overlong_flag;
        end
    end

endmodule

@@ rtl/core/scfp_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module scfp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  scfp_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_busy,
    output scfp_pkg::t_result o_result
);
    import scfp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_busy  = r_valid && i_stall;
    assign n_valid = i_load || o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/core/sum_checked_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_checked_frame_parser
// Datapath: a taken byte is held in the input register and its parsed result
// in the result register. Throughput: one byte per cycle when no stall holds
// the flow; the parse step is combinational between the two registers.
// Reset: synchronous, active low; clears frame state and both stage valids.
// Parses length-prefixed frames with a 16-bit sum checksum, byte by byte.
// ----------------------------------------------------------------------------
module sum_checked_frame_parser #(
    parameter int MAX_PACKAGE_BYTES = scfp_pkg::MAX_PACKAGE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_package,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_item_kind,
    output logic [7:0] o_payload_byte,
    output logic [2:0] o_verdict
);
    import scfp_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    logic    has_result;
    logic    out_busy;
    t_result result;
    t_result out_result;

    assign in_item.rx_byte        = i_rx_byte;
    assign in_item.end_of_package = i_end_of_package;

    assign advance = stage_valid && (!has_result || !out_busy);

    scfp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (in_item),
        .i_advance    (advance),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    scfp_parse #(
        .MAX_PACKAGE_BYTES (MAX_PACKAGE_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (stage_item),
        .i_advance    (advance),
        .o_has_result (has_result),
        .o_result     (result)
    );

    scfp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_busy   (out_busy),
        .o_result (out_result)
    );

    assign o_item_kind    = out_result.item_kind;
    assign o_payload_byte = out_result.payload_byte;
    assign o_verdict      = out_result.verdict;

endmodule
